@@ hw/rtl/cvl_pkg.sv @@
// Shared types and codes for the compacting value list.
package cvl_pkg;

    localparam int VALUE_W = 32;

    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_SEARCH = 3'd2;
    localparam logic [2:0] CMD_READ   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_NOTFOUND = 2'd1;
    localparam logic [1:0] STAT_FULL     = 2'd2;
    localparam logic [1:0] STAT_RANGE    = 2'd3;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_CMP,
        CELL_SHIFT,
        CELL_APPEND,
        CELL_COMPACT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage

@@ hw/rtl/cvl_cell.sv @@
// One list cell: holds an entry and a match flag, appends, compares, shifts and compacts.
module cvl_cell
    import cvl_pkg::*;
#(
    parameter int POS = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic [CW-1:0]      count,
    input  logic [IW-1:0]      del_pos,
    input  logic [VALUE_W-1:0] entry_in,
    input  logic               hit_in,
    output logic [VALUE_W-1:0] entry,
    output logic               hit
);

    localparam logic [8:0] POS_W = 9'(POS);

    logic [VALUE_W-1:0] entry_reg;
    logic               hit_reg;
    logic               in_use;

    assign in_use = POS_W < 9'(count);

    always_ff @(posedge clk)
    begin
        unique case (ctl.op)
            CELL_APPEND:
            begin
                if (POS_W == 9'(count))
                begin
                    entry_reg <= ctl.value;
                end
            end
            CELL_COMPACT:
            begin
                if (POS_W >= 9'(del_pos))
                begin
                    entry_reg <= entry_in;
                end
            end
            default:
            begin
                entry_reg <= entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            unique case (ctl.op)
                CELL_CMP:
                begin
                    hit_reg <= in_use && (entry_reg == ctl.value);
                end
                CELL_SHIFT:
                begin
                    hit_reg <= hit_in;
                end
                default:
                begin
                    hit_reg <= hit_reg;
                end
            endcase
        end
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

@@ hw/rtl/compacting_value_list_top.sv @@
// Top level of the compacting value list: command sequencer and row of cells.
//
//  channel | dir | tdata                      | tuser
//  s_*     | in  | value[31:0] index[35:32]   | command[2:0]
//  m_*     | out | position[3:0] read_value[35:4] entry_count[40:36] | status[1:0]
//
//  Append, read, clear and unused codes finish in the accept cycle.
//  Search and delete load match flags into every cell, then shift them toward
//  cell 0 one position per cycle until a hit reaches cell 0 or every used
//  entry has been scanned; a delete that hits adds a compaction shift step.
//  Reset empties the list; entry storage is not cleared.
//  A new word is taken only when the sequencer is idle and the output slot is
//  free or draining; a stalled output holds the sequencer in its final step.
module compacting_value_list_top
    import cvl_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], index[35:32], zero fill
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // position[3:0], read_value[35:4], entry_count[40:36]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int RD_N = (ENTRIES < 16) ? ENTRIES : 16;
    localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [IW-1:0]       scan_reg, scan_next;
    logic [IW-1:0]       pos_reg, pos_next;
    logic [2:0]          cmd_reg, cmd_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [1:0]          st_reg, st_next;

    logic                mv_reg, mv_next;
    logic [1:0]          mstat_reg, mstat_next;
    logic [3:0]          mpos_reg, mpos_next;
    logic [VALUE_W-1:0]  mrd_reg, mrd_next;
    logic [4:0]          mcnt_reg, mcnt_next;

    logic                accept;
    logic                out_free;
    logic [2:0]          in_cmd;
    logic [VALUE_W-1:0]  in_value;
    logic [3:0]          in_index;
    logic                idx_ok;
    logic [VALUE_W-1:0]  rd_val;

    logic                load_out;
    logic [1:0]          out_stat;
    logic [3:0]          out_pos;
    logic [VALUE_W-1:0]  out_rd;
    logic [8:0]          cnt_wide;
    logic [7:0]          pos_wide;

    cell_ctl_t           ctl;
    logic [VALUE_W-1:0]  entry_w [ENTRIES];
    logic                hit_w   [ENTRIES];

    assign in_cmd   = s_tuser;
    assign in_value = s_tdata[31:0];
    assign in_index = s_tdata[35:32];

    assign out_free = !mv_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign idx_ok   = 9'(in_index) < 9'(count_reg);
    assign pos_wide = 8'(pos_reg);

    always_comb
    begin
        rd_val = '0;
        for (int j = 0; j < RD_N; j++)
        begin
            if (in_index == 4'(j))
            begin
                rd_val = entry_w[j];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        scan_next  = scan_reg;
        pos_next   = pos_reg;
        cmd_next   = cmd_reg;
        val_next   = val_reg;
        st_next    = st_reg;
        mv_next    = mv_reg && !m_tready;
        mstat_next = mstat_reg;
        mpos_next  = mpos_reg;
        mrd_next   = mrd_reg;
        mcnt_next  = mcnt_reg;
        ctl.op     = CELL_HOLD;
        ctl.value  = val_reg;
        load_out   = 1'b0;
        out_stat   = STAT_OK;
        out_pos    = '0;
        out_rd     = '0;
        cnt_wide   = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = in_cmd;
                    val_next = in_value;
                    unique case (in_cmd)
                        CMD_APPEND:
                        begin
                            load_out = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                out_stat = STAT_FULL;
                            end
                            else
                            begin
                                ctl.op     = CELL_APPEND;
                                ctl.value  = in_value;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_DELETE, CMD_SEARCH:
                        begin
                            state_next = S_CMP;
                        end
                        CMD_READ:
                        begin
                            load_out = 1'b1;
                            if (idx_ok)
                            begin
                                out_rd = rd_val;
                            end
                            else
                            begin
                                out_stat = STAT_RANGE;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            load_out   = 1'b1;
                            count_next = '0;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP:
            begin
                ctl.op     = CELL_CMP;
                scan_next  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (hit_w[0])
                begin
                    pos_next   = scan_reg;
                    st_next    = STAT_OK;
                    state_next = (cmd_reg == CMD_DELETE) ? S_SHIFT : S_DONE;
                end
                else if ((9'(scan_reg) + 9'd1) >= 9'(count_reg))
                begin
                    pos_next   = '0;
                    st_next    = STAT_NOTFOUND;
                    state_next = S_DONE;
                end
                else
                begin
                    ctl.op    = CELL_SHIFT;
                    scan_next = scan_reg + IW'(1);
                end
            end
            S_SHIFT:
            begin
                ctl.op     = CELL_COMPACT;
                count_next = count_reg - CW'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    out_stat   = st_reg;
                    out_pos    = pos_wide[3:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_out)
        begin
            cnt_wide   = 9'(count_next);
            mv_next    = 1'b1;
            mstat_next = out_stat;
            mpos_next  = out_pos;
            mrd_next   = out_rd;
            mcnt_next  = cnt_wide[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg  <= scan_next;
        pos_reg   <= pos_next;
        cmd_reg   <= cmd_next;
        val_reg   <= val_next;
        st_reg    <= st_next;
        mstat_reg <= mstat_next;
        mpos_reg  <= mpos_next;
        mrd_reg   <= mrd_next;
        mcnt_reg  <= mcnt_next;
    end

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        logic [VALUE_W-1:0] nb_entry;
        logic               nb_hit;

        if (i == ENTRIES - 1)
        begin : g_last
            assign nb_entry = entry_w[i];
            assign nb_hit   = 1'b0;
        end
        else
        begin : g_mid
            assign nb_entry = entry_w[i+1];
            assign nb_hit   = hit_w[i+1];
        end

        cvl_cell #(
            .POS (i),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .count    (count_reg),
            .del_pos  (pos_reg),
            .entry_in (nb_entry),
            .hit_in   (nb_hit),
            .entry    (entry_w[i]),
            .hit      (hit_w[i])
        );
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = mstat_reg;
    assign m_tdata  = {7'd0, mcnt_reg, mrd_reg, mpos_reg};

endmodule

@@ hw/rtl/cvl_checker.sv @@
// Port-level checks for the compacting value list, bound to the top level.
module cvl_checker
    import cvl_pkg::*;
#(
    parameter int ENTRIES = 16
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser
);

    localparam logic [4:0] FULL_CNT5 = 5'(ENTRIES);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output word changed");

    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output slot blocked");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == STAT_FULL) |-> m_tdata[40:36] == FULL_CNT5)
        else $error("full status with count below capacity");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == STAT_NOTFOUND) || (m_tuser == STAT_RANGE))
        |-> (m_tdata[3:0] == 4'd0) && (m_tdata[35:4] == 32'd0))
        else $error("failed command reports position or data");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (ENTRIES > 31) || (m_tdata[40:36] <= FULL_CNT5))
        else $error("entry count above capacity");

endmodule

bind compacting_value_list_top cvl_checker #(
    .ENTRIES (ENTRIES)
) u_cvl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
